/* hw/rtl/x86mov_pkg.sv */
package x86mov_pkg;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_UNKNOWN   = 2'd1,
        STATUS_TRUNCATED = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        POS_OPCODE  = 2'd0,
        POS_MODRM   = 2'd1,
        POS_DATA_LO = 2'd2,
        POS_DATA_HI = 2'd3
    } pos_t;

    typedef enum logic [1:0] {
        KIND_RM      = 2'd0,
        KIND_IMM     = 2'd1,
        KIND_UNKNOWN = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        DISP_NONE = 2'd0,
        DISP_BYTE = 2'd1,
        DISP_WORD = 2'd2
    } disp_t;

    localparam logic [5:0] RM_OPCODE_TAG  = 6'b100010;
    localparam logic [3:0] IMM_OPCODE_TAG = 4'b1011;
    localparam logic [1:0] MOD_MEM        = 2'b00;
    localparam logic [1:0] MOD_DISP8      = 2'b01;
    localparam logic [1:0] MOD_DISP16     = 2'b10;
    localparam logic [2:0] RM_DIRECT      = 3'b110;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       end_of_stream;
    } in_t;

    typedef struct packed {
        logic        form;
        status_t     status;
        logic        wide;
        logic        reg_is_dest;
        logic [1:0]  mode_bits;
        logic [2:0]  reg_field;
        logic [2:0]  rm_field;
        logic [15:0] displacement;
        logic [15:0] immediate;
    } out_t;

    function automatic kind_t op_kind(input logic [7:0] op);
        if (op[7:2] == RM_OPCODE_TAG) begin
            return KIND_RM;
        end else if (op[7:4] == IMM_OPCODE_TAG) begin
            return KIND_IMM;
        end
        return KIND_UNKNOWN;
    endfunction

    function automatic disp_t disp_size(input logic [7:0] modrm);
        logic [1:0] md;
        md = modrm[7:6];
        if (md == MOD_MEM) begin
            return (modrm[2:0] == RM_DIRECT) ? DISP_WORD : DISP_NONE;
        end else if (md == MOD_DISP8) begin
            return DISP_BYTE;
        end else if (md == MOD_DISP16) begin
            return DISP_WORD;
        end
        return DISP_NONE;
    endfunction

endpackage

/* hw/rtl/x86_16_mov_decoder.sv */
// Decoder for the 8086 MOV forms register/memory to/from register (100010dw)
// and immediate to register (1011wreg), fed one code byte per request.
// Input channel s_*: one byte per request, end_of_stream marks the last
// byte of the stream. Result channel m_*: one decoded instruction per request,
// given on the request that completes it. An unknown opcode swallows the next
// byte and reports status unknown; a stream that ends mid-instruction reports
// status truncated on its last byte and decoding restarts at an opcode.
// Timing: a byte accepted into the input register is decoded from there, and
// its result is registered in the result register, which drives m_valid; a
// stalled receiver can hold it in between. Throughput: one byte per cycle while
// m_ready keeps up, set by the single decode pass between the two registers.
// Bytes inside an instruction give no result and simply move the position.
// A stalled receiver holds the result register; one more byte is taken into
// the input register, then s_ready drops until m_ready returns.
// Reset (aresetn low, synchronous) empties both registers and puts the
// decoder back at the opcode position.
module x86_16_mov_decoder (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  x86mov_pkg::in_t       s_payload,
    output logic                  m_valid,
    input  logic                  m_ready,
    output x86mov_pkg::out_t      m_payload
);
    import x86mov_pkg::*;

    logic        in_valid_reg;
    in_t         in_reg;
    logic        advance;
    logic        step;

    pos_t        pos_reg, pos_next;
    logic [7:0]  opcode_reg, opcode_next;
    logic [7:0]  modrm_reg, modrm_next;
    logic [7:0]  lo_reg, lo_next;

    logic        m_valid_reg;
    out_t        m_payload_reg;
    logic        res_valid;
    out_t        res;

    logic [7:0]  b;
    logic        eos;
    kind_t       kind_held;
    kind_t       kind_byte;
    disp_t       disp_byte;
    disp_t       disp_held;

    assign advance = !m_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;
    assign step    = in_valid_reg && advance;

    assign b         = in_reg.code_byte;
    assign eos       = in_reg.end_of_stream;
    assign kind_held = op_kind(opcode_reg);
    assign kind_byte = op_kind(b);
    assign disp_byte = disp_size(b);
    assign disp_held = disp_size(modrm_reg);

    function automatic out_t rm_result(input logic [7:0] op, input logic [7:0] m,
                                       input logic [15:0] disp);
        out_t r;
        r              = '0;
        r.form         = 1'b0;
        r.status       = STATUS_OK;
        r.wide         = op[0];
        r.reg_is_dest  = op[1];
        r.mode_bits    = m[7:6];
        r.reg_field    = m[5:3];
        r.rm_field     = m[2:0];
        r.displacement = disp;
        return r;
    endfunction

    function automatic out_t imm_result(input logic [7:0] op, input logic [15:0] imm);
        out_t r;
        r             = '0;
        r.form        = 1'b1;
        r.status      = STATUS_OK;
        r.wide        = op[3];
        r.reg_is_dest = 1'b1;
        r.reg_field   = op[2:0];
        r.immediate   = imm;
        return r;
    endfunction

    function automatic out_t trunc_result(input logic form);
        out_t r;
        r        = '0;
        r.form   = form;
        r.status = STATUS_TRUNCATED;
        return r;
    endfunction

    // next position and held bytes
    always_comb begin
        pos_next    = POS_OPCODE;
        opcode_next = opcode_reg;
        modrm_next  = modrm_reg;
        lo_next     = lo_reg;
        unique case (pos_reg)
            POS_OPCODE: begin
                opcode_next = b;
                if (!eos) pos_next = POS_MODRM;
            end
            POS_MODRM: begin
                case (kind_held)
                    KIND_RM: begin
                        modrm_next = b;
                        if (disp_byte != DISP_NONE && !eos) pos_next = POS_DATA_LO;
                    end
                    KIND_IMM: begin
                        lo_next = b;
                        if (opcode_reg[3] && !eos) pos_next = POS_DATA_LO;
                    end
                    default: ;
                endcase
            end
            POS_DATA_LO: begin
                if (kind_held == KIND_RM) begin
                    lo_next = b;
                    if (disp_held == DISP_WORD && !eos) pos_next = POS_DATA_HI;
                end
            end
            POS_DATA_HI: ;
        endcase
    end

    // result for the byte in the input register
    always_comb begin
        res_valid = 1'b0;
        res       = '0;
        unique case (pos_reg)
            POS_OPCODE: begin
                if (eos) begin
                    res_valid = 1'b1;
                    res       = trunc_result(kind_byte == KIND_IMM);
                end
            end
            POS_MODRM: begin
                case (kind_held)
                    KIND_RM: begin
                        if (disp_byte == DISP_NONE) begin
                            res_valid = 1'b1;
                            res       = rm_result(opcode_reg, b, 16'h0000);
                        end else if (eos) begin
                            res_valid = 1'b1;
                            res       = trunc_result(1'b0);
                        end
                    end
                    KIND_IMM: begin
                        if (!opcode_reg[3]) begin
                            res_valid = 1'b1;
                            res       = imm_result(opcode_reg, {8'h00, b});
                        end else if (eos) begin
                            res_valid = 1'b1;
                            res       = trunc_result(1'b1);
                        end
                    end
                    default: begin
                        res_valid  = 1'b1;
                        res.status = STATUS_UNKNOWN;
                    end
                endcase
            end
            POS_DATA_LO: begin
                case (kind_held)
                    KIND_RM: begin
                        if (disp_held == DISP_BYTE) begin
                            res_valid = 1'b1;
                            res       = rm_result(opcode_reg, modrm_reg, {8'h00, b});
                        end else if (eos) begin
                            res_valid = 1'b1;
                            res       = trunc_result(1'b0);
                        end
                    end
                    KIND_IMM: begin
                        res_valid = 1'b1;
                        res       = imm_result(opcode_reg, {b, lo_reg});
                    end
                    default: ;
                endcase
            end
            POS_DATA_HI: begin
                if (kind_held == KIND_RM) begin
                    res_valid = 1'b1;
                    res       = rm_result(opcode_reg, modrm_reg, {b, lo_reg});
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_payload;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= POS_OPCODE;
        end else if (step) begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            opcode_reg <= 8'h00;
            modrm_reg  <= 8'h00;
            lo_reg     <= 8'h00;
        end else if (step) begin
            opcode_reg <= opcode_next;
            modrm_reg  <= modrm_next;
            lo_reg     <= lo_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= step && res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && res_valid) begin
            m_payload_reg <= res;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // a finished instruction always returns the decoder to the opcode byte
    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && res_valid) |=> (pos_reg == POS_OPCODE))
        else $error("decoder did not restart after a result");

    a_unknown_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload.status == STATUS_UNKNOWN) |->
        (!m_payload.form && m_payload.displacement == 16'h0000 &&
         m_payload.immediate == 16'h0000 && m_payload.reg_field == 3'd0))
        else $error("unknown opcode result carries data");

    a_trunc_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload.status == STATUS_TRUNCATED) |->
        (!m_payload.wide && m_payload.displacement == 16'h0000 &&
         m_payload.immediate == 16'h0000))
        else $error("truncated result carries data");

    a_imm_form: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload.status == STATUS_OK && m_payload.form) |->
        (m_payload.reg_is_dest && m_payload.mode_bits == 2'd0 &&
         m_payload.displacement == 16'h0000))
        else $error("immediate result has register/memory fields");

    a_rm_form: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload.status == STATUS_OK && !m_payload.form) |->
        (m_payload.immediate == 16'h0000))
        else $error("register/memory result has immediate data");

endmodule
